// File: hdl/sbeq_pkg.sv
// Shared types and constants of the spectrum band equalizer.
`timescale 1ns / 1ps
package sbeq_pkg;

  localparam int FREQ_W        = 12;
  localparam int BANDS_W       = 6;
  localparam int BAND_IDX_W    = 5;
  localparam int GAIN_W        = 16;
  localparam int FRAC_W        = 14;
  localparam int QUEUE_DEPTH   = 4;

  localparam int MAX_BANDS_DEF   = 32;
  localparam int SAMPLE_BITS_DEF = 24;
  localparam int MAX_BINS_DEF    = 2049;

  localparam logic [GAIN_W-1:0]  UNITY_GAIN    = 16'd16384;
  localparam logic [FREQ_W-1:0]  NUM_FREQS_RST = 12'd513;
  localparam logic [BANDS_W-1:0] NUM_BANDS_RST = 6'd1;

  typedef enum logic {
    OP_GAIN = 1'b0,
    OP_BIN  = 1'b1
  } op_t;

  typedef enum logic [0:0] {
    CFG_NUM_FREQS = 1'b0,
    CFG_NUM_BANDS = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    op_t                   op;
    logic [BAND_IDX_W-1:0] idx;
  } ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV0,
    ST_ADDR,
    ST_READ,
    ST_SUM,
    ST_DIV1,
    ST_SCALE,
    ST_OUT
  } state_t;

endpackage

// File: hdl/sbeq_front.sv
// Front end: accepts items, classifies them and feeds the item queue.
`timescale 1ns / 1ps
module sbeq_front #(
  parameter int MAX_BANDS   = sbeq_pkg::MAX_BANDS_DEF,
  parameter int SAMPLE_BITS = sbeq_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              push,
  output logic                              full,
  input  logic                              in_req_type,
  input  logic [sbeq_pkg::BAND_IDX_W-1:0]   in_band_index,
  input  logic [sbeq_pkg::GAIN_W-1:0]       in_band_gain,
  input  logic signed [SAMPLE_BITS-1:0]     in_bin_real,
  input  logic signed [SAMPLE_BITS-1:0]     in_bin_imag,
  input  logic                              q_full,
  output logic                              q_wr,
  output logic [$bits(sbeq_pkg::ctl_t)+sbeq_pkg::GAIN_W+2*SAMPLE_BITS-1:0] q_wdata
);

  sbeq_pkg::ctl_t ctl;
  logic           keep;

  always_comb begin
    ctl.op  = sbeq_pkg::op_t'(in_req_type);
    ctl.idx = in_band_index;
    // gain writes outside the table have no effect and are dropped here
    keep    = (ctl.op == sbeq_pkg::OP_BIN) || (32'(in_band_index) < MAX_BANDS);
    q_wr    = push && !q_full && keep;
    q_wdata = {ctl, in_band_gain, in_bin_real, in_bin_imag};
  end

  assign full = q_full;

endmodule

// File: hdl/sbeq_fifo.sv
// Short item queue between front end and back end.
`timescale 1ns / 1ps
module sbeq_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = sbeq_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             rd,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);
  assign rdata = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (wr) begin
      entry_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (rd) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (wr && !rd) begin
        count_r <= count_r + 1'b1;
      end else if (rd && !wr) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr && full && !rd))
    else $error("item queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(rd && empty))
    else $error("item queue read while empty");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("item queue count out of range");
`endif

endmodule

// File: hdl/sbeq_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module sbeq_div #(
  parameter int DVD_W = 28,
  parameter int DVS_W = sbeq_pkg::FREQ_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             busy,
  output logic [DVD_W-1:0] quotient,
  output logic [DVS_W-1:0] remainder
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] dq_r;
  logic [DVS_W-1:0] rem_r, dvs_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic [DVS_W:0]   trial;
  logic             ge;

  always_comb begin
    trial = {rem_r, dq_r[DVD_W-1]};
    ge    = (trial >= {1'b0, dvs_r});
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq_r  <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      dq_r  <= {dq_r[DVD_W-2:0], ge};
      rem_r <= ge ? DVS_W'(trial - {1'b0, dvs_r}) : DVS_W'(trial);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(DVD_W);
    end else if (busy_r) begin
      cnt_r  <= cnt_r - 1'b1;
      busy_r <= (cnt_r != CNT_W'(1));
    end
  end

  assign busy      = busy_r;
  assign quotient  = dq_r;
  assign remainder = rem_r;

endmodule

// File: hdl/sbeq_back.sv
// Back end: gain table, gain interpolation, bin scaling and result register.
`timescale 1ns / 1ps
module sbeq_back #(
  parameter int MAX_BANDS   = sbeq_pkg::MAX_BANDS_DEF,
  parameter int SAMPLE_BITS = sbeq_pkg::SAMPLE_BITS_DEF,
  parameter int MAX_BINS    = sbeq_pkg::MAX_BINS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [sbeq_pkg::FREQ_W-1:0]     num_freqs,
  input  logic [sbeq_pkg::BANDS_W-1:0]    num_bands,
  input  logic                            q_empty,
  input  logic [$bits(sbeq_pkg::ctl_t)+sbeq_pkg::GAIN_W+2*SAMPLE_BITS-1:0] q_data,
  output logic                            q_pop,
  output logic                            empty,
  input  logic                            pop,
  output logic signed [SAMPLE_BITS-1:0]   out_real,
  output logic signed [SAMPLE_BITS-1:0]   out_imag,
  output logic                            out_spectrum_end,
  output logic                            out_clipped
);

  localparam int F_W    = sbeq_pkg::FREQ_W;
  localparam int GN_W   = sbeq_pkg::GAIN_W;
  localparam int FR_W   = sbeq_pkg::FRAC_W;
  localparam int IDX_W  = $clog2(MAX_BANDS);
  localparam int NB_W   = $clog2(MAX_BANDS + 1);
  localparam int CTL_W  = $bits(sbeq_pkg::ctl_t);
  localparam int P_W    = F_W + NB_W;
  localparam int G_W    = F_W + GN_W;
  localparam int DVD_W  = (P_W > G_W) ? P_W : G_W;
  localparam int PROD_W = SAMPLE_BITS + GN_W + 1;
  localparam int TOP_W  = PROD_W - FR_W - SAMPLE_BITS + 1;

  sbeq_pkg::state_t state_r, state_nxt;

  sbeq_pkg::ctl_t                q_ctl;
  logic [GN_W-1:0]               q_gain;
  logic signed [SAMPLE_BITS-1:0] q_re, q_im;

  logic [F_W-1:0]  nf_c;
  logic [NB_W-1:0] nb_c, nbm1;
  logic [P_W-1:0]  pos_num;
  logic            last_c;

  logic            div_start, div_busy;
  logic [DVD_W-1:0] div_dvd, div_quo;
  logic [F_W-1:0]  div_rem;

  logic            tbl_we, cap, rd_en, out_load;
  logic            past_end, use_last;
  logic [IDX_W-1:0] addr0, addr1;

  logic [GN_W-1:0] tbl_r [MAX_BANDS];
  logic            vld_r [MAX_BANDS];

  logic [F_W-1:0]  bin_pos_r, rem_r;
  logic signed [SAMPLE_BITS-1:0] x_re_r, x_im_r;
  logic            last_r, single_r, interp_r;
  logic [GN_W-1:0] rd0_r, rd1_r, gain_r, g0, g1;
  logic            rdv0_r, rdv1_r;
  logic [G_W-1:0]  p0_r, p1_r;
  logic signed [GN_W:0] gain_s;
  logic signed [PROD_W-1:0] prod_re_r, prod_im_r;
  logic [SAMPLE_BITS:0] sat_re, sat_im;

  logic                          out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_real_r, out_imag_r;
  logic                          out_end_r, out_clip_r;

  function automatic logic [SAMPLE_BITS:0] saturate(input logic signed [PROD_W-1:0] p);
    logic [TOP_W-1:0] top;
    top = p[PROD_W-1:FR_W+SAMPLE_BITS-1];
    if ((top == '0) || (top == '1)) begin
      saturate = {1'b0, p[FR_W +: SAMPLE_BITS]};
    end else if (p[PROD_W-1]) begin
      saturate = {1'b1, 1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      saturate = {1'b1, 1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  endfunction

  always_comb begin
    q_ctl  = q_data[CTL_W+GN_W+2*SAMPLE_BITS-1 -: CTL_W];
    q_gain = q_data[2*SAMPLE_BITS +: GN_W];
    q_re   = q_data[SAMPLE_BITS +: SAMPLE_BITS];
    q_im   = q_data[0 +: SAMPLE_BITS];
  end

  // configuration clamps
  always_comb begin
    if (num_freqs == '0) begin
      nf_c = F_W'(1);
    end else if (32'(num_freqs) > MAX_BINS) begin
      nf_c = F_W'(MAX_BINS);
    end else begin
      nf_c = num_freqs;
    end
    if (num_bands == '0) begin
      nb_c = NB_W'(1);
    end else if (32'(num_bands) > MAX_BANDS) begin
      nb_c = NB_W'(MAX_BANDS);
    end else begin
      nb_c = NB_W'(num_bands);
    end
    nbm1    = nb_c - 1'b1;
    pos_num = P_W'(bin_pos_r) * P_W'(nbm1);
    last_c  = ({1'b0, bin_pos_r} + 1'b1) >= {1'b0, nf_c};
  end

  sbeq_div #(
    .DVD_W (DVD_W),
    .DVS_W (F_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dvd),
    .divisor   (nf_c),
    .busy      (div_busy),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_comb begin
    past_end = (DVD_W'(nbm1) <= div_quo);
    use_last = single_r || past_end;
    if (single_r) begin
      addr0 = '0;
    end else if (past_end) begin
      addr0 = IDX_W'(nbm1);
    end else begin
      addr0 = IDX_W'(div_quo);
    end
    addr1 = IDX_W'(div_quo) + 1'b1;
    g0    = rdv0_r ? rd0_r : sbeq_pkg::UNITY_GAIN;
    g1    = rdv1_r ? rd1_r : sbeq_pkg::UNITY_GAIN;
    gain_s = {1'b0, gain_r};
    sat_re = saturate(prod_re_r);
    sat_im = saturate(prod_im_r);
  end

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    div_start = 1'b0;
    div_dvd   = '0;
    tbl_we    = 1'b0;
    cap       = 1'b0;
    rd_en     = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      sbeq_pkg::ST_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          if (q_ctl.op == sbeq_pkg::OP_GAIN) begin
            tbl_we = 1'b1;
          end else begin
            cap = 1'b1;
            if (nb_c == NB_W'(1)) begin
              state_nxt = sbeq_pkg::ST_ADDR;
            end else begin
              div_start = 1'b1;
              div_dvd   = DVD_W'(pos_num);
              state_nxt = sbeq_pkg::ST_DIV0;
            end
          end
        end
      end
      sbeq_pkg::ST_DIV0: begin
        if (!div_busy) begin
          state_nxt = sbeq_pkg::ST_ADDR;
        end
      end
      sbeq_pkg::ST_ADDR: begin
        rd_en     = 1'b1;
        state_nxt = sbeq_pkg::ST_READ;
      end
      sbeq_pkg::ST_READ: begin
        state_nxt = interp_r ? sbeq_pkg::ST_SUM : sbeq_pkg::ST_SCALE;
      end
      sbeq_pkg::ST_SUM: begin
        div_start = 1'b1;
        div_dvd   = DVD_W'(p0_r) + DVD_W'(p1_r);
        state_nxt = sbeq_pkg::ST_DIV1;
      end
      sbeq_pkg::ST_DIV1: begin
        if (!div_busy) begin
          state_nxt = sbeq_pkg::ST_SCALE;
        end
      end
      sbeq_pkg::ST_SCALE: begin
        state_nxt = sbeq_pkg::ST_OUT;
      end
      sbeq_pkg::ST_OUT: begin
        if (!out_valid_r || pop) begin
          out_load  = 1'b1;
          state_nxt = sbeq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sbeq_pkg::ST_IDLE;
      end
    endcase
  end

  // gain table
  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_r[IDX_W'(q_ctl.idx)] <= q_gain;
    end
    if (rd_en) begin
      rd0_r  <= tbl_r[addr0];
      rd1_r  <= tbl_r[addr1];
      rdv0_r <= vld_r[addr0];
      rdv1_r <= vld_r[addr1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < MAX_BANDS; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else if (tbl_we) begin
      vld_r[IDX_W'(q_ctl.idx)] <= 1'b1;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (cap) begin
      x_re_r   <= q_re;
      x_im_r   <= q_im;
      last_r   <= last_c;
      single_r <= (nb_c == NB_W'(1));
    end
    if (rd_en) begin
      interp_r <= !use_last;
      rem_r    <= div_rem;
    end
    if (state_r == sbeq_pkg::ST_READ) begin
      gain_r <= g0;
      p0_r   <= G_W'(nf_c - rem_r) * G_W'(g0);
      p1_r   <= G_W'(rem_r) * G_W'(g1);
    end
    if ((state_r == sbeq_pkg::ST_DIV1) && !div_busy) begin
      gain_r <= GN_W'(div_quo);
    end
    if (state_r == sbeq_pkg::ST_SCALE) begin
      prod_re_r <= x_re_r * gain_s;
      prod_im_r <= x_im_r * gain_s;
    end
    if (out_load) begin
      out_real_r <= sat_re[SAMPLE_BITS-1:0];
      out_imag_r <= sat_im[SAMPLE_BITS-1:0];
      out_end_r  <= last_r;
      out_clip_r <= sat_re[SAMPLE_BITS] || sat_im[SAMPLE_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sbeq_pkg::ST_IDLE;
      bin_pos_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cap) begin
        bin_pos_r <= last_c ? '0 : bin_pos_r + 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign empty            = !out_valid_r;
  assign out_real         = out_real_r;
  assign out_imag         = out_imag_r;
  assign out_spectrum_end = out_end_r;
  assign out_clipped      = out_clip_r;

`ifndef SYNTHESIS
  a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");
  a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || pop))
    else $error("waiting result overwritten");
  a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> !empty)
    else $error("loaded result not presented");
  a_pop_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> ((state_r == sbeq_pkg::ST_IDLE) && !q_empty))
    else $error("queue popped outside idle");
`endif

endmodule

// File: hdl/spectrum_band_equalizer_unit.sv
// Top level of the spectrum band equalizer.
//
//   channel  direction  handshake            payload
//   input    in         push / full          in_req_type, in_band_index, in_band_gain,
//                                            in_bin_real, in_bin_imag
//   result   out        empty / pop          out_real, out_imag, out_spectrum_end,
//                                            out_clipped
//   config   in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A gain write is stored from the idle state of the back end. A bin with
// interpolation runs the bit-serial divider (28 steps) twice, a bin past
// the last band runs it once, and with one band it does not run at all.
// A 4-item queue lets items be accepted while the back end is busy.
// Reset is synchronous, active low; gain table reads unity until written.
// A finished result waits in the output register; the back end stalls only
// when that register is still full.
`timescale 1ns / 1ps
module spectrum_band_equalizer_unit #(
  parameter int MAX_BANDS   = sbeq_pkg::MAX_BANDS_DEF,
  parameter int SAMPLE_BITS = sbeq_pkg::SAMPLE_BITS_DEF,
  parameter int MAX_BINS    = sbeq_pkg::MAX_BINS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            push,
  output logic                            full,
  input  logic                            in_req_type,
  input  logic [sbeq_pkg::BAND_IDX_W-1:0] in_band_index,
  input  logic [sbeq_pkg::GAIN_W-1:0]     in_band_gain,
  input  logic signed [SAMPLE_BITS-1:0]   in_bin_real,
  input  logic signed [SAMPLE_BITS-1:0]   in_bin_imag,
  output logic                            empty,
  input  logic                            pop,
  output logic signed [SAMPLE_BITS-1:0]   out_real,
  output logic signed [SAMPLE_BITS-1:0]   out_imag,
  output logic                            out_spectrum_end,
  output logic                            out_clipped,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  sbeq_pkg::cfg_reg_t              cfg_index,
  input  logic [sbeq_pkg::FREQ_W-1:0]     cfg_data
);

  localparam int ITEM_W = $bits(sbeq_pkg::ctl_t) + sbeq_pkg::GAIN_W + 2 * SAMPLE_BITS;

  logic [sbeq_pkg::FREQ_W-1:0]  num_freqs_r;
  logic [sbeq_pkg::BANDS_W-1:0] num_bands_r;

  logic              q_wr, q_full, q_rd, q_empty;
  logic [ITEM_W-1:0] q_wdata, q_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_freqs_r <= sbeq_pkg::NUM_FREQS_RST;
      num_bands_r <= sbeq_pkg::NUM_BANDS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        sbeq_pkg::CFG_NUM_FREQS: num_freqs_r <= cfg_data;
        sbeq_pkg::CFG_NUM_BANDS: num_bands_r <= cfg_data[sbeq_pkg::BANDS_W-1:0];
      endcase
    end
  end

  sbeq_front #(
    .MAX_BANDS   (MAX_BANDS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .push          (push),
    .full          (full),
    .in_req_type   (in_req_type),
    .in_band_index (in_band_index),
    .in_band_gain  (in_band_gain),
    .in_bin_real   (in_bin_real),
    .in_bin_imag   (in_bin_imag),
    .q_full        (q_full),
    .q_wr          (q_wr),
    .q_wdata       (q_wdata)
  );

  sbeq_fifo #(
    .WIDTH (ITEM_W),
    .DEPTH (sbeq_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (q_wr),
    .wdata (q_wdata),
    .full  (q_full),
    .rd    (q_rd),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  sbeq_back #(
    .MAX_BANDS   (MAX_BANDS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_BINS    (MAX_BINS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .num_freqs        (num_freqs_r),
    .num_bands        (num_bands_r),
    .q_empty          (q_empty),
    .q_data           (q_rdata),
    .q_pop            (q_rd),
    .empty            (empty),
    .pop              (pop),
    .out_real         (out_real),
    .out_imag         (out_imag),
    .out_spectrum_end (out_spectrum_end),
    .out_clipped      (out_clipped)
  );

endmodule
